@@ sv/lcbm_pkg.sv @@
`default_nettype none
package lcbm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_UNITS = 16;
  localparam int unsigned DIV_STEPS = 8;

  localparam logic [3:0] REGION_PRG = 4'hA;
  localparam logic [3:0] REGION_LOW_FD = 4'hB;
  localparam logic [3:0] REGION_LOW_FE = 4'hC;
  localparam logic [3:0] REGION_HIGH_FD = 4'hD;
  localparam logic [3:0] REGION_HIGH_FE = 4'hE;
  localparam logic [3:0] REGION_MIRROR = 4'hF;

  localparam logic [9:0] TILE_LOW_FD = 10'h0FD;
  localparam logic [9:0] TILE_LOW_FE = 10'h0FE;
  localparam logic [9:0] TILE_HIGH_FD = 10'h1FD;
  localparam logic [9:0] TILE_HIGH_FE = 10'h1FE;

  localparam logic OP_CPU_WRITE = 1'b0;
  localparam logic REG_PROGRAM_BANKS = 1'b0;
  localparam logic REG_PATTERN_SIZE = 1'b1;

  localparam logic [6:0] HIGH_PAGE_RESET = 7'd4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PRG,
    CMD_LOW_FD,
    CMD_LOW_FE,
    CMD_HIGH_FD,
    CMD_HIGH_FE,
    CMD_MIRROR,
    CMD_SEL_LOW_FD,
    CMD_SEL_LOW_FE,
    CMD_SEL_HIGH_FD,
    CMD_SEL_HIGH_FE
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [4:0] clamp_units(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (v > 5'(MAX_UNITS)) begin
      r = 5'(MAX_UNITS);
    end
    return r;
  endfunction

  function automatic logic needs_divide(input cmd_code_t c);
    return (c == CMD_PRG) || (c == CMD_LOW_FD) || (c == CMD_LOW_FE) ||
           (c == CMD_HIGH_FD) || (c == CMD_HIGH_FE);
  endfunction

endpackage
`default_nettype wire

@@ sv/lcbm_if.sv @@
`default_nettype none
interface lcbm_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, operation, address, data, input ready);
  modport sink (input valid, operation, address, data, output ready);
endinterface

interface lcbm_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] program_page;
  logic [6:0] pattern_page_low;
  logic [6:0] pattern_page_high;
  logic       mirror_vertical;

  modport source (output valid, program_page, pattern_page_low, pattern_page_high,
                  mirror_vertical, input ready);
  modport sink (input valid, program_page, pattern_page_low, pattern_page_high,
                mirror_vertical, output ready);
endinterface

interface lcbm_setup_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [4:0] value;

  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface
`default_nettype wire

@@ sv/lcbm_front.sv @@
`default_nettype none
module lcbm_front
  import lcbm_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  output logic             push_valid,
  input  wire logic        push_ready,
  output cmd_t             push_cmd
);

  cmd_code_t code;

  always_comb begin
    code = CMD_NONE;
    if (operation == OP_CPU_WRITE) begin
      unique case (address[15:12])
        REGION_PRG:     code = CMD_PRG;
        REGION_LOW_FD:  code = CMD_LOW_FD;
        REGION_LOW_FE:  code = CMD_LOW_FE;
        REGION_HIGH_FD: code = CMD_HIGH_FD;
        REGION_HIGH_FE: code = CMD_HIGH_FE;
        REGION_MIRROR:  code = CMD_MIRROR;
        default:        code = CMD_NONE;
      endcase
    end else begin
      unique case (address[13:4])
        TILE_LOW_FD:  code = CMD_SEL_LOW_FD;
        TILE_LOW_FE:  code = CMD_SEL_LOW_FE;
        TILE_HIGH_FD: code = CMD_SEL_HIGH_FD;
        TILE_HIGH_FE: code = CMD_SEL_HIGH_FE;
        default:      code = CMD_NONE;
      endcase
    end
  end

  assign in_ready = push_ready;
  assign push_valid = in_valid;
  assign push_cmd = '{code: code, data: data};

endmodule
`default_nettype wire

@@ sv/lcbm_queue.sv @@
`default_nettype none
module lcbm_queue
  import lcbm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_cmd = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/lcbm_back.sv @@
`default_nettype none
module lcbm_back
  import lcbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [4:0] program_banks,
  input  wire logic [4:0] pattern_rom_size,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  wire cmd_t       pop_cmd,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      program_page,
  output logic [6:0]      pattern_page_low,
  output logic [6:0]      pattern_page_high,
  output logic            mirror_vertical
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam int unsigned SW = $clog2(DIV_STEPS);

  logic [1:0]    state;
  logic [1:0]    state_next;
  cmd_code_t     work_code;
  logic [7:0]    dividend;
  logic [4:0]    rem;
  logic [5:0]    divisor;
  logic [SW-1:0] step;

  logic [4:0] program_page_reg;
  logic [6:0] low_fd_bank;
  logic [6:0] low_fe_bank;
  logic [6:0] high_fd_bank;
  logic [6:0] high_fe_bank;
  logic       low_latch;
  logic       high_latch;
  logic [6:0] applied_low;
  logic [6:0] applied_high;
  logic       mirror_reg;

  logic       out_free;
  logic       pop_now;
  logic       apply_en;
  cmd_code_t  apply_code;
  logic [7:0] apply_data;
  logic [5:0] trial;
  logic [5:0] load_divisor;
  logic [4:0] prg_val;
  logic [6:0] pat_val;

  logic [4:0] program_page_next;
  logic [6:0] low_fd_next;
  logic [6:0] low_fe_next;
  logic [6:0] high_fd_next;
  logic [6:0] high_fe_next;
  logic       low_latch_next;
  logic       high_latch_next;
  logic [6:0] applied_low_next;
  logic [6:0] applied_high_next;
  logic       mirror_next;

  assign out_free = !out_valid || out_ready;
  assign pop_ready = (state == ST_IDLE) && (needs_divide(pop_cmd.code) || out_free);
  assign pop_now = pop_valid && pop_ready;
  assign trial = {rem, dividend[7]};
  assign load_divisor = (pop_cmd.code == CMD_PRG) ? {1'b0, clamp_units(program_banks)}
                                                  : {clamp_units(pattern_rom_size), 1'b0};
  assign prg_val = {rem[3:0], 1'b0};
  assign pat_val = {rem, 2'b00};

  always_comb begin
    apply_en = 1'b0;
    apply_code = pop_cmd.code;
    apply_data = pop_cmd.data;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_now) begin
          if (needs_divide(pop_cmd.code)) begin
            state_next = ST_DIV;
          end else begin
            apply_en = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (step == SW'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        apply_code = work_code;
        if (out_free) begin
          apply_en = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    program_page_next = program_page_reg;
    low_fd_next = low_fd_bank;
    low_fe_next = low_fe_bank;
    high_fd_next = high_fd_bank;
    high_fe_next = high_fe_bank;
    low_latch_next = low_latch;
    high_latch_next = high_latch;
    applied_low_next = applied_low;
    applied_high_next = applied_high;
    mirror_next = mirror_reg;
    unique case (apply_code)
      CMD_PRG: program_page_next = prg_val;
      CMD_LOW_FD: begin
        low_fd_next = pat_val;
        if (!low_latch) begin
          applied_low_next = pat_val;
        end
      end
      CMD_LOW_FE: begin
        low_fe_next = pat_val;
        if (low_latch) begin
          applied_low_next = pat_val;
        end
      end
      CMD_HIGH_FD: begin
        high_fd_next = pat_val;
        if (!high_latch) begin
          applied_high_next = pat_val;
        end
      end
      CMD_HIGH_FE: begin
        high_fe_next = pat_val;
        if (high_latch) begin
          applied_high_next = pat_val;
        end
      end
      CMD_MIRROR: mirror_next = !apply_data[0];
      CMD_SEL_LOW_FD: begin
        low_latch_next = 1'b0;
        applied_low_next = low_fd_bank;
      end
      CMD_SEL_LOW_FE: begin
        low_latch_next = 1'b1;
        applied_low_next = low_fe_bank;
      end
      CMD_SEL_HIGH_FD: begin
        high_latch_next = 1'b0;
        applied_high_next = high_fd_bank;
      end
      CMD_SEL_HIGH_FE: begin
        high_latch_next = 1'b1;
        applied_high_next = high_fe_bank;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop_now) begin
      work_code <= pop_cmd.code;
      dividend <= pop_cmd.data;
      divisor <= load_divisor;
      rem <= '0;
    end else if (state == ST_DIV) begin
      dividend <= {dividend[6:0], 1'b0};
      if (trial >= divisor) begin
        rem <= 5'(trial - divisor);
      end else begin
        rem <= trial[4:0];
      end
    end
    if (apply_en) begin
      program_page <= program_page_next;
      pattern_page_low <= applied_low_next;
      pattern_page_high <= applied_high_next;
      mirror_vertical <= mirror_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      out_valid <= 1'b0;
      program_page_reg <= '0;
      low_fd_bank <= '0;
      low_fe_bank <= '0;
      high_fd_bank <= '0;
      high_fe_bank <= '0;
      low_latch <= 1'b1;
      high_latch <= 1'b1;
      applied_low <= '0;
      applied_high <= HIGH_PAGE_RESET;
      mirror_reg <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step <= step + SW'(1);
      end else begin
        step <= '0;
      end
      if (apply_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (apply_en) begin
        program_page_reg <= program_page_next;
        low_fd_bank <= low_fd_next;
        low_fe_bank <= low_fe_next;
        high_fd_bank <= high_fd_next;
        high_fe_bank <= high_fe_next;
        low_latch <= low_latch_next;
        high_latch <= high_latch_next;
        applied_low <= applied_low_next;
        applied_high <= applied_high_next;
        mirror_reg <= mirror_next;
      end
    end
  end

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == SW'(DIV_STEPS - 1)) |=> (state == ST_DONE))
    else $error("divide did not finish after its last step");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_DONE) |-> ({1'b0, rem} < divisor))
    else $error("remainder not below divisor");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop_now |-> (state == ST_IDLE))
    else $error("command taken while busy");

  a_sel_low_fd: assert property (@(posedge clk) disable iff (rst)
    (apply_en && apply_code == CMD_SEL_LOW_FD)
    |=> (!low_latch && applied_low == $past(low_fd_bank) && pattern_page_low == applied_low))
    else $error("low latch select did not map its bank");

  a_apply_shows: assert property (@(posedge clk) disable iff (rst)
    apply_en |=> (out_valid && program_page == program_page_reg &&
                  pattern_page_high == applied_high && mirror_vertical == mirror_reg))
    else $error("result does not show the mapping");

endmodule
`default_nettype wire

@@ sv/latched_chr_bank_mapper.sv @@
// Bank mapper with tile-fetch latches for a cartridge with program and pattern ROM.
// Channels: item (sink) carries CPU register writes and pattern fetch addresses,
// result (source) carries the page mapping after each item, and setup (sink)
// writes the program bank count (index 0) and pattern ROM size (index 1).
// Setup is always ready and is meant to be written only while the block is idle.
// Each accepted item gives exactly one result transaction.
// A fetch, a mirroring write or an unmapped write passes through a queue slot into
// the result register; such items sustain one per cycle while the receiver stays ready
// and no bank write is ahead. A bank write uses the bit-serial remainder unit that
// reduces the bank number by the bank count in eight steps; others wait behind it.
// Items are classified on entry and held in a small queue, so the item channel
// stays ready while the result register waits for the receiver.
// When the receiver stalls, the result is held, the queue fills, then item.ready drops.
// Reset clears the queue, both bank counts read as 16, all banks and the program
// page read as zero, both latches select FE, the high half maps page four, and
// mirroring reads as horizontal.
`default_nettype none
module latched_chr_bank_mapper
  import lcbm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  lcbm_item_if.sink    item,
  lcbm_result_if.source result,
  lcbm_setup_if.sink   setup
);

  logic [4:0] program_banks;
  logic [4:0] pattern_rom_size;
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;

  assign setup.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_banks <= 5'(MAX_UNITS);
      pattern_rom_size <= 5'(MAX_UNITS);
    end else if (setup.valid) begin
      unique case (setup.index)
        REG_PROGRAM_BANKS: program_banks <= setup.value;
        REG_PATTERN_SIZE:  pattern_rom_size <= setup.value;
        default: begin
        end
      endcase
    end
  end

  lcbm_front u_front (
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .operation  (item.operation),
    .address    (item.address),
    .data       (item.data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lcbm_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lcbm_back u_back (
    .clk               (clk),
    .rst               (rst),
    .program_banks     (program_banks),
    .pattern_rom_size  (pattern_rom_size),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_cmd           (pop_cmd),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .program_page      (result.program_page),
    .pattern_page_low  (result.pattern_page_low),
    .pattern_page_high (result.pattern_page_high),
    .mirror_vertical   (result.mirror_vertical)
  );

endmodule
`default_nettype wire

@@ dv/lcbm_mapping_checker.sv @@
`timescale 1ns / 100ps
module lcbm_mapping_checker
  import lcbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        item_operation,
  input  logic [15:0] item_address,
  input  logic [7:0]  item_data,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [4:0]  result_program_page,
  input  logic [6:0]  result_pattern_page_low,
  input  logic [6:0]  result_pattern_page_high,
  input  logic        result_mirror_vertical,
  input  logic        setup_valid,
  input  logic        setup_ready,
  input  logic        setup_index,
  input  logic [4:0]  setup_value,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [4:0] program_page;
    logic [6:0] low_page;
    logic [6:0] high_page;
    logic       mirror_vertical;
  } page_map_t;

  page_map_t  expected_maps[$];
  int         errors;

  logic [4:0] prg_bank_count;
  logic [4:0] chr_rom_size;
  logic [4:0] prg_page;
  logic [6:0] low_fd_bank;
  logic [6:0] low_fe_bank;
  logic [6:0] high_fd_bank;
  logic [6:0] high_fe_bank;
  logic       low_latch_fe;
  logic       high_latch_fe;
  logic [6:0] low_page;
  logic [6:0] high_page;
  logic       mirror_vertical;

  function automatic int unsigned bank_units(input logic [4:0] v);
    if (v == 5'd0) begin
      return 1;
    end
    return (v > 5'd16) ? 16 : int'(v);
  endfunction

  function automatic logic [6:0] chr_page_of(input logic [7:0] d);
    int unsigned count;
    count = bank_units(chr_rom_size) * 2;
    return 7'((d % count) << 2);
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endtask

  task automatic apply_transaction(input logic op, input logic [15:0] addr,
                                   input logic [7:0] d);
    logic [6:0] page;
    if (op == OP_CPU_WRITE) begin
      page = chr_page_of(d);
      case (addr[15:12])
        REGION_PRG: prg_page = 5'((d % bank_units(prg_bank_count)) << 1);
        REGION_LOW_FD: begin
          low_fd_bank = page;
          if (!low_latch_fe) low_page = page;
        end
        REGION_LOW_FE: begin
          low_fe_bank = page;
          if (low_latch_fe) low_page = page;
        end
        REGION_HIGH_FD: begin
          high_fd_bank = page;
          if (!high_latch_fe) high_page = page;
        end
        REGION_HIGH_FE: begin
          high_fe_bank = page;
          if (high_latch_fe) high_page = page;
        end
        REGION_MIRROR: mirror_vertical = ~d[0];
        default: ;
      endcase
    end else begin
      case (addr[13:4])
        TILE_LOW_FD: begin
          low_latch_fe = 1'b0;
          low_page = low_fd_bank;
        end
        TILE_LOW_FE: begin
          low_latch_fe = 1'b1;
          low_page = low_fe_bank;
        end
        TILE_HIGH_FD: begin
          high_latch_fe = 1'b0;
          high_page = high_fd_bank;
        end
        TILE_HIGH_FE: begin
          high_latch_fe = 1'b1;
          high_page = high_fe_bank;
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    page_map_t want;
    if (rst) begin
      expected_maps.delete();
      errors = 0;
      prg_bank_count = 5'd16;
      chr_rom_size = 5'd16;
      prg_page = '0;
      low_fd_bank = '0;
      low_fe_bank = '0;
      high_fd_bank = '0;
      high_fe_bank = '0;
      low_latch_fe = 1'b1;
      high_latch_fe = 1'b1;
      low_page = '0;
      high_page = HIGH_PAGE_RESET;
      mirror_vertical = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_maps.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors++;
        end else begin
          want = expected_maps.pop_front();
          check_field("program_page", want.program_page, result_program_page);
          check_field("pattern_page_low", want.low_page, result_pattern_page_low);
          check_field("pattern_page_high", want.high_page, result_pattern_page_high);
          check_field("mirror_vertical", want.mirror_vertical, result_mirror_vertical);
        end
      end
      if (setup_valid && setup_ready) begin
        if (setup_index == REG_PROGRAM_BANKS) begin
          prg_bank_count = setup_value;
        end else begin
          chr_rom_size = setup_value;
        end
      end
      if (item_valid && item_ready) begin
        apply_transaction(item_operation, item_address, item_data);
        expected_maps.push_back('{prg_page, low_page, high_page, mirror_vertical});
      end
    end
    fail_count <= errors;
    pending <= expected_maps.size();
  end

endmodule

@@ dv/latched_chr_bank_mapper_test.sv @@
`timescale 1ns / 100ps
module latched_chr_bank_mapper_test;
  import lcbm_pkg::*;

  localparam logic OP_PATTERN_FETCH = 1'b1;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 141;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   cycles;
  int   writes_sent;
  int   fetches_sent;

  lcbm_item_if   item_ch ();
  lcbm_result_if result_ch ();
  lcbm_setup_if  setup_ch ();

  latched_chr_bank_mapper uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .setup  (setup_ch)
  );

  lcbm_mapping_checker mapping_check (
    .clk                      (clk),
    .rst                      (rst),
    .item_valid               (item_ch.valid),
    .item_ready               (item_ch.ready),
    .item_operation           (item_ch.operation),
    .item_address             (item_ch.address),
    .item_data                (item_ch.data),
    .result_valid             (result_ch.valid),
    .result_ready             (result_ch.ready),
    .result_program_page      (result_ch.program_page),
    .result_pattern_page_low  (result_ch.pattern_page_low),
    .result_pattern_page_high (result_ch.pattern_page_high),
    .result_mirror_vertical   (result_ch.mirror_vertical),
    .setup_valid              (setup_ch.valid),
    .setup_ready              (setup_ch.ready),
    .setup_index              (setup_ch.index),
    .setup_value              (setup_ch.value),
    .fail_count               (fail_count),
    .pending                  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.operation <= op;
    item_ch.address <= addr;
    item_ch.data <= d;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (op == OP_CPU_WRITE) begin
      writes_sent++;
    end else begin
      fetches_sent++;
    end
  endtask

  task automatic send_random_item();
    logic [7:0]  d;
    logic [9:0]  tile;
    logic [3:0]  region;
    int          pick;
    d = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) d = $urandom_range(1) ? 8'hFF : 8'h00;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(3))
        0: tile = TILE_LOW_FD;
        1: tile = TILE_LOW_FE;
        2: tile = TILE_HIGH_FD;
        default: tile = TILE_HIGH_FE;
      endcase
      send_item(OP_PATTERN_FETCH,
                {2'($urandom_range(3)), tile, 4'($urandom_range(15))}, d);
    end else if (pick < 55) begin
      send_item(OP_PATTERN_FETCH, 16'($urandom_range(65535)), d);
    end else if (pick < 90) begin
      region = 4'($urandom_range(REGION_PRG, REGION_MIRROR));
      send_item(OP_CPU_WRITE, {region, 12'($urandom_range(4095))}, d);
    end else begin
      send_item(OP_CPU_WRITE, 16'($urandom_range(65535)), d);
    end
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_bank_counts(input logic [4:0] prg_count, input logic [4:0] chr_size);
    setup_ch.valid <= 1'b1;
    setup_ch.index <= REG_PROGRAM_BANKS;
    setup_ch.value <= prg_count;
    @(posedge clk);
    while (!setup_ch.ready) @(posedge clk);
    setup_ch.index <= REG_PATTERN_SIZE;
    setup_ch.value <= chr_size;
    @(posedge clk);
    while (!setup_ch.ready) @(posedge clk);
    setup_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [4:0] prg_setting [PHASES];
    logic [4:0] chr_setting [PHASES];
    prg_setting = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'($urandom_range(31))};
    chr_setting = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd16, 5'd12, 5'($urandom_range(31))};
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    writes_sent = 0;
    fetches_sent = 0;
    item_ch.valid = 1'b0;
    item_ch.operation = OP_CPU_WRITE;
    item_ch.address = '0;
    item_ch.data = '0;
    setup_ch.valid = 1'b0;
    setup_ch.index = REG_PROGRAM_BANKS;
    setup_ch.value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_PATTERN_FETCH, {2'b00, TILE_LOW_FD, 4'h0}, 8'h00);
    send_item(OP_CPU_WRITE, {REGION_LOW_FE, 12'h000}, 8'hFF);
    send_item(OP_PATTERN_FETCH, {2'b00, TILE_LOW_FE, 4'h8}, 8'h5A);
    send_item(OP_CPU_WRITE, {REGION_LOW_FD, 12'hFFF}, 8'h00);
    send_item(OP_CPU_WRITE, {REGION_HIGH_FD, 12'h123}, 8'h80);
    send_item(OP_CPU_WRITE, {REGION_HIGH_FE, 12'h000}, 8'h07);
    send_item(OP_PATTERN_FETCH, {2'b00, TILE_HIGH_FD, 4'h5}, 8'hFF);
    send_item(OP_CPU_WRITE, {REGION_HIGH_FE, 12'h800}, 8'h1F);
    send_item(OP_PATTERN_FETCH, {2'b00, TILE_HIGH_FE, 4'hF}, 8'h00);
    send_item(OP_PATTERN_FETCH, {2'b11, TILE_LOW_FD, 4'h0}, 8'h00);
    send_item(OP_PATTERN_FETCH, 16'h2FE0, 8'h00);
    send_item(OP_PATTERN_FETCH, 16'h0FF0, 8'h00);
    send_item(OP_PATTERN_FETCH, 16'hFFFF, 8'hFF);
    send_item(OP_CPU_WRITE, {REGION_PRG, 12'h000}, 8'hFF);
    send_item(OP_CPU_WRITE, {REGION_PRG, 12'hFFF}, 8'h10);
    send_item(OP_CPU_WRITE, {REGION_PRG, 12'h456}, 8'h07);
    send_item(OP_CPU_WRITE, {REGION_MIRROR, 12'h000}, 8'h00);
    send_item(OP_CPU_WRITE, {REGION_MIRROR, 12'hFFF}, 8'hFF);
    send_item(OP_CPU_WRITE, {REGION_MIRROR, 12'h123}, 8'hFE);
    send_item(OP_CPU_WRITE, 16'h0000, 8'hFF);
    send_item(OP_CPU_WRITE, 16'h9FFF, 8'hAA);
    send_item(OP_CPU_WRITE, 16'h8000, 8'h55);
    send_item(OP_PATTERN_FETCH, 16'h0000, 8'hFF);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      set_bank_counts(prg_setting[phase], chr_setting[phase]);
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct = 24;
          stall_pct = 24;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    wait_idle();
    repeat (16) @(posedge clk);
    $display("Covered %0d transactions (%0d CPU writes, %0d pattern fetches) over %0d bank-count",
             writes_sent + fetches_sent, writes_sent, fetches_sent, PHASES);
    $display("settings including out-of-range values, with sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lcbm_pkg.sv
sv/lcbm_if.sv
sv/lcbm_front.sv
sv/lcbm_queue.sv
sv/lcbm_back.sv
sv/latched_chr_bank_mapper.sv
dv/lcbm_mapping_checker.sv
dv/latched_chr_bank_mapper_test.sv
